### rtl/base64_encoder_line_wrapped_defines.svh
// Assertion macros shared by the base64 line-wrapped encoder RTL.
`ifndef BASE64_ENCODER_LINE_WRAPPED_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAPPED_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define B64LW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define B64LW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define B64LW_ASSERT(label, clk, rst_n, prop)
`define B64LW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/b64lw_pkg.sv
// Package with the types, constants and alphabet of the base64 line-wrapped encoder.
`default_nettype none

package b64lw_pkg;

    localparam logic [6:0] LINE_LIMIT = 7'd70;
    localparam logic [6:0] COUNT_MAX  = 7'd127;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [2:0] LAST_IDX_PLAIN = 3'd3;
    localparam logic [2:0] LAST_IDX_CRLF  = 3'd5;

    // One encoded group: four characters, then CR and LF when a line break follows.
    typedef struct packed {
        logic [5:0][7:0] chars;
        logic            crlf;
        logic            eom;
    } t_group;

    // Maps a 6-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                b64_char = 8'h41 + w;
            end else if (v < 6'd52) begin
                b64_char = 8'h61 + w - 8'd26;
            end else if (v < 6'd62) begin
                b64_char = 8'h30 + w - 8'd52;
            end else if (v == 6'd62) begin
                b64_char = 8'h2B;
            end else begin
                b64_char = 8'h2F;
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/b64lw_enc.sv
// Byte gathering, group encoding and line counting with a one-entry group register.
`default_nettype none

module b64lw_enc
    import b64lw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_byte_present,
    input  wire logic       i_end_of_message,
    output logic            o_grp_valid,
    output t_group          o_grp,
    input  wire logic       i_grp_take
);

    logic       r_lbe;
    logic [7:0] r_p0, r_p1;
    logic [1:0] r_pcount;
    logic [6:0] r_lcount;
    logic       r_grp_valid;
    t_group     r_grp;

    logic [7:0] n_p0, n_p1;
    logic [1:0] n_pcount;
    logic [6:0] n_lcount;
    t_group     n_grp;

    logic       accept;
    logic       full;
    logic       flush;
    logic       has_grp;
    logic [1:0] eff_cnt;
    logic [7:0] b0, b1, b2;
    logic       have2, have3;
    logic [7:0] sum;
    logic [6:0] cnt;
    logic       crlf;

    assign o_stall     = r_grp_valid;
    assign accept      = i_valid & ~r_grp_valid;
    assign o_grp_valid = r_grp_valid;
    assign o_grp       = r_grp;

    always_comb begin
        // A byte arriving with two pending completes a group; otherwise it is stored.
        full    = i_byte_present & r_pcount[1];
        eff_cnt = r_pcount + {1'b0, i_byte_present & ~r_pcount[1]};
        n_p0    = (i_byte_present && r_pcount == 2'd0) ? i_data_byte : r_p0;
        n_p1    = (i_byte_present && r_pcount == 2'd1) ? i_data_byte : r_p1;
        flush   = i_end_of_message & ~full & (eff_cnt != 2'd0);
        has_grp = full | flush;

        b0    = full ? r_p0 : n_p0;
        b1    = full ? r_p1 : ((eff_cnt == 2'd2) ? n_p1 : 8'd0);
        b2    = full ? i_data_byte : 8'd0;
        have2 = full | (eff_cnt == 2'd2);
        have3 = full;

        n_grp.chars[0] = b64_char(b0[7:2]);
        n_grp.chars[1] = b64_char({b0[1:0], b1[7:4]});
        n_grp.chars[2] = have2 ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD;
        n_grp.chars[3] = have3 ? b64_char(b2[5:0]) : CHAR_PAD;
        n_grp.chars[4] = CHAR_CR;
        n_grp.chars[5] = CHAR_LF;

        // The line count saturates, so it keeps growing with breaks disabled.
        sum  = {1'b0, r_lcount} + 8'd4;
        cnt  = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[6:0];
        crlf = r_lbe & (cnt > LINE_LIMIT);

        n_grp.crlf = crlf;
        n_grp.eom  = i_end_of_message;

        if (i_end_of_message) begin
            n_lcount = 7'd0;
        end else if (has_grp) begin
            n_lcount = crlf ? 7'd0 : cnt;
        end else begin
            n_lcount = r_lcount;
        end

        n_pcount = (i_end_of_message | full) ? 2'd0 : eff_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbe       <= 1'b0;
            r_pcount    <= 2'd0;
            r_lcount    <= 7'd0;
            r_grp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lbe <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pcount <= n_pcount;
                r_lcount <= n_lcount;
            end
            if (accept && has_grp) begin
                r_grp_valid <= 1'b1;
            end else if (i_grp_take) begin
                r_grp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
        if (accept && has_grp) begin
            r_grp <= n_grp;
        end
    end

endmodule

`default_nettype wire

### rtl/b64lw_ser.sv
// Serializer that sends the characters of one group a word at a time.
`default_nettype none

module b64lw_ser
    import b64lw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_grp_valid,
    input  wire t_group     i_grp,
    output logic            o_grp_take,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    output logic            o_message_last
);

    logic            r_busy;
    logic [2:0]      r_idx;
    logic [2:0]      r_last_idx;
    logic            r_eom;
    logic [5:0][7:0] r_chars;

    logic is_last;
    logic sent;
    logic free;

    assign is_last        = (r_idx == r_last_idx);
    assign sent           = r_busy & ~i_stall;
    assign free           = ~r_busy | (sent & is_last);
    assign o_grp_take     = i_grp_valid & free;

    assign o_valid        = r_busy;
    assign o_out_char     = r_chars[r_idx];
    assign o_run_last     = is_last;
    assign o_message_last = is_last & r_eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_grp_take) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (sent) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_take) begin
            r_chars    <= i_grp.chars;
            r_eom      <= i_grp.eom;
            r_last_idx <= i_grp.crlf ? LAST_IDX_CRLF : LAST_IDX_PLAIN;
        end
    end

endmodule

`default_nettype wire

### rtl/base64_encoder_line_wrapped.sv
// Top level of the base64 encoder with optional CR LF line wrapping.
//
// The input channel takes one word per accepted item: a raw byte with a
// presence flag and an end-of-message flag. It is accepted when i_valid is
// high and o_stall is low. The output channel sends one character per word
// (alphabet, '=' pad, CR or LF) with run-last and message-last flags, taken
// when o_valid is high and i_stall is low.
// Every third byte, or an end flag with one or two bytes pending, forms a
// group of four characters, followed by CR LF when wrapping is enabled and
// the line passes 70 characters. The group is encoded combinationally into
// a one-entry group register; a serializer then sends one character per
// cycle while the receiver does not stall. The first character is
// presented once the group has moved from the group register into the
// serializer. Items are taken every cycle while the group register is
// empty; any item waits while it holds a group, so a byte stream is paced
// by the one-character output.
// Reset clears the pending bytes, the line count and the wrap enable, and
// empties both the group register and the serializer. When the receiver
// stalls, the current character holds and the block keeps taking items
// until the group register fills, then raises o_stall.
`default_nettype none

`include "base64_encoder_line_wrapped_defines.svh"

module base64_encoder_line_wrapped
    import b64lw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_byte_present,
    input  wire logic       i_end_of_message,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    output logic            o_message_last
);

    logic   grp_valid;
    logic   grp_take;
    t_group grp;

    // Encoder: holds the message state and the finished group.
    b64lw_enc u_enc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_grp_valid      (grp_valid),
        .o_grp            (grp),
        .i_grp_take       (grp_take)
    );

    // Serializer: loads a group when idle or as soon as the last character of the current one goes out.
    b64lw_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grp_valid    (grp_valid),
        .i_grp          (grp),
        .o_grp_take     (grp_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_message_last (o_message_last)
    );

    // The final character of a message always closes its item's run.
    `B64LW_ASSERT(a_msg_last_run_last, i_clk, i_rst_n, !(o_valid && o_message_last) || o_run_last)

    // A waiting group is picked up at once by an idle serializer.
    `B64LW_ASSERT_NEXT(a_idle_loads, i_clk, i_rst_n, grp_valid && !o_valid, o_valid)

    // With nothing waiting, the output goes idle after the last word of a run.
    `B64LW_ASSERT_NEXT(a_run_end_idle, i_clk, i_rst_n,
        o_valid && o_run_last && !i_stall && !grp_valid, !o_valid)

endmodule

`default_nettype wire
